/* src/integer_field_parser_top_defines.svh */
// Assertion macros for the integer field parser.
// Used by integer_field_parser_top; no other dependencies.
`ifndef INTEGER_FIELD_PARSER_TOP_DEFINES_SVH
`define INTEGER_FIELD_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge outside reset
`define IFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on the cycle after a trigger condition
`define IFP_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);
`else
`define IFP_ASSERT(label, clk, rst_n, prop, msg)
`define IFP_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg)
`endif

`endif

/* src/ifp_pkg.sv */
// Shared types, codes and helper functions for the integer field parser.
// No dependencies.
package ifp_pkg;

    // Field width limit after reset (32767, the largest value the 15-bit width holds)
    localparam logic [14:0] MAX_FIELD_WIDTH = 15'd32767;

    // Configuration register indexes
    localparam logic [1:0] CFG_CONV_MODE = 2'd0;
    localparam logic [1:0] CFG_MAX_WIDTH = 2'd1;
    localparam logic [1:0] CFG_SIZE_MODE = 2'd2;

    // Conversion modes
    localparam logic [2:0] CONV_AUTO = 3'd0;
    localparam logic [2:0] CONV_BIN  = 3'd1;
    localparam logic [2:0] CONV_OCT  = 3'd2;
    localparam logic [2:0] CONV_DEC  = 3'd3;
    localparam logic [2:0] CONV_HEX  = 3'd4;

    // Destination sizes
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_DIGIT = 2'd1;
    localparam logic [1:0] STATUS_EOF      = 2'd2;
    localparam logic [1:0] STATUS_NO_VALUE = 2'd3;

    typedef enum logic [1:0] {
        RADIX_2,
        RADIX_8,
        RADIX_10,
        RADIX_16
    } t_radix;

    // Numeric value of a radix code
    function automatic logic [4:0] radix_value(input t_radix rad);
        logic [4:0] v;
        case (rad)
            RADIX_2:  v = 5'd2;
            RADIX_8:  v = 5'd8;
            RADIX_10: v = 5'd10;
            default:  v = 5'd16;
        endcase
        return v;
    endfunction

    // accum * radix with 64-bit wrap, as shifts and at most one add
    function automatic logic [63:0] mul_radix(input logic [63:0] a, input t_radix rad);
        logic [63:0] p;
        case (rad)
            RADIX_2:  p = a << 1;
            RADIX_8:  p = a << 3;
            RADIX_10: p = (a << 3) + (a << 1);
            default:  p = a << 4;
        endcase
        return p;
    endfunction

endpackage

/* src/integer_field_parser_top.sv */
// Integer field parser: one character per cycle, scanf-style integer conversion.
// The result of the character that ends a field is offered in the cycle after
// that character's transfer. Throughput: one character per cycle if not stalled;
// single-pass digit update (shift-add, compare) and one output register set it.
// Reset (synchronous, active low) restores register defaults and starts a new field.
// Depends on ifp_pkg and integer_field_parser_top_defines.svh.
`include "integer_field_parser_top_defines.svh"

module integer_field_parser_top
    import ifp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    // character input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tuser,   // [0] is_eof
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [63:0] value, [79:64] chars_taken
    output logic [2:0]  m_axis_tuser    // [1:0] status, [2] char_unused
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    // configuration
    logic [2:0]  r_conv_mode;
    logic [14:0] r_max_width;
    logic [1:0]  r_size_mode;

    // field state
    t_phase      r_phase,      n_phase;
    logic [14:0] r_width_left, n_width_left;
    logic [63:0] r_accum,      n_accum;
    logic        r_negative,   n_negative;
    t_radix      r_radix,      n_radix;
    logic        r_got_digit,  n_got_digit;
    logic [15:0] r_taken,      n_taken;

    // result register
    logic        r_out_valid;
    logic [63:0] r_out_value;
    logic [1:0]  r_out_status;
    logic        r_out_unused;
    logic [15:0] r_out_taken;

    // step outputs
    logic        fin;
    logic [1:0]  fin_status;
    logic        fin_unused;
    logic [63:0] fin_value;
    logic        take;
    logic        do_start;
    logic        do_digit;
    t_radix      dig_radix;
    logic        in_fire;
    logic        c_eof;
    logic [7:0]  c;
    logic        c_space;
    logic        c_sign;
    logic        c_prefix;
    logic        dig_ok;
    logic [3:0]  dig;
    logic [63:0] signed_acc;

    assign c     = s_axis_tdata;
    assign c_eof = s_axis_tuser;

    // Accept a new character whenever the result register is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign c_space  = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    assign c_sign   = (c == "+") || (c == "-");
    assign c_prefix = (c == "b") || (c == "B") || (c == "x") || (c == "X");

    // Decode a hex-style digit
    always_comb begin
        dig_ok = 1'b1;
        dig    = 4'd0;
        if (c >= "0" && c <= "9") begin
            dig = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            dig = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            dig = 4'(c - "A" + 8'd10);
        end else begin
            dig_ok = 1'b0;
        end
    end

    // Advance the field state by one character
    always_comb begin
        n_phase      = r_phase;
        n_width_left = r_width_left;
        n_accum      = r_accum;
        n_negative   = r_negative;
        n_radix      = r_radix;
        n_got_digit  = r_got_digit;
        fin          = 1'b0;
        fin_status   = STATUS_OK;
        fin_unused   = 1'b0;
        take         = 1'b0;
        do_start     = 1'b0;
        do_digit     = 1'b0;
        dig_radix    = r_radix;

        unique case (r_phase)
            PH_SKIP: begin
                if (c_eof) begin
                    fin        = 1'b1;
                    fin_status = STATUS_EOF;
                end else if (c_space) begin
                    take = 1'b1;
                end else if (c_sign) begin
                    n_negative = (c == "-");
                    if (r_width_left != 15'd0) begin
                        n_width_left = r_width_left - 15'd1;
                    end
                    take    = 1'b1;
                    n_phase = PH_SIGNED;
                end else begin
                    do_start = 1'b1;
                end
            end
            PH_SIGNED: do_start = 1'b1;
            PH_ZERO: begin
                n_phase = PH_DIGITS;
                if (!c_eof && c_prefix) begin
                    n_radix     = ((c == "b") || (c == "B")) ? RADIX_2 : RADIX_16;
                    n_got_digit = 1'b0;
                    take        = 1'b1;
                end else begin
                    do_digit = 1'b1;
                end
            end
            default: do_digit = 1'b1;
        endcase

        // First character after spaces and any sign: pick the radix, catch an auto-mode leading zero
        if (do_start) begin
            if (r_conv_mode == CONV_AUTO && !c_eof && c == "0" && r_width_left != 15'd0) begin
                take        = 1'b1;
                n_radix     = RADIX_8;
                n_got_digit = 1'b1;
                n_phase     = PH_ZERO;
            end else begin
                case (r_conv_mode)
                    CONV_BIN: dig_radix = RADIX_2;
                    CONV_OCT: dig_radix = RADIX_8;
                    CONV_HEX: dig_radix = RADIX_16;
                    default:  dig_radix = RADIX_10;
                endcase
                n_radix  = dig_radix;
                n_phase  = PH_DIGITS;
                do_digit = 1'b1;
            end
        end

        // Digit step: end the field or accumulate one digit negatively
        if (do_digit) begin
            if (r_width_left == 15'd0) begin
                fin        = 1'b1;
                fin_status = r_got_digit ? STATUS_OK : (c_eof ? STATUS_EOF : STATUS_NO_VALUE);
                fin_unused = !c_eof;
            end else if (c_eof) begin
                fin        = 1'b1;
                fin_status = r_got_digit ? STATUS_OK : STATUS_EOF;
            end else if (!dig_ok) begin
                fin        = 1'b1;
                fin_status = r_got_digit ? STATUS_OK : STATUS_NO_DIGIT;
                fin_unused = 1'b1;
            end else if ({1'b0, dig} >= radix_value(dig_radix)) begin
                fin        = 1'b1;
                fin_status = r_got_digit ? STATUS_OK : STATUS_NO_VALUE;
                fin_unused = 1'b1;
            end else begin
                n_accum      = mul_radix(r_accum, dig_radix) - {60'd0, dig};
                n_got_digit  = 1'b1;
                n_width_left = r_width_left - 15'd1;
                take         = 1'b1;
            end
        end

        n_taken = (take && r_taken != 16'hFFFF) ? r_taken + 16'd1 : r_taken;
    end

    // Apply the sign, truncate to the destination size and sign-extend; an error result is zero
    always_comb begin
        signed_acc = r_negative ? r_accum : (64'd0 - r_accum);
        if (fin_status != STATUS_OK) begin
            fin_value = 64'd0;
        end else begin
            case (r_size_mode)
                SIZE_8:  fin_value = {{56{signed_acc[7]}}, signed_acc[7:0]};
                SIZE_16: fin_value = {{48{signed_acc[15]}}, signed_acc[15:0]};
                SIZE_32: fin_value = {{32{signed_acc[31]}}, signed_acc[31:0]};
                default: fin_value = signed_acc;
            endcase
        end
    end

    // Hold configuration, field state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv_mode  <= CONV_DEC;
            r_max_width  <= MAX_FIELD_WIDTH;
            r_size_mode  <= SIZE_32;
            r_phase      <= PH_SKIP;
            r_width_left <= MAX_FIELD_WIDTH;
            r_accum      <= 64'd0;
            r_negative   <= 1'b0;
            r_radix      <= RADIX_10;
            r_got_digit  <= 1'b0;
            r_taken      <= 16'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CONV_MODE: r_conv_mode <= i_cfg_data[2:0];
                    CFG_MAX_WIDTH: r_max_width <= i_cfg_data;
                    CFG_SIZE_MODE: r_size_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            // Raise valid on a finishing transfer, drop it once the sink takes the result
            if (in_fire && fin) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (in_fire) begin
                if (fin) begin
                    // field done: clear for the next field and load the result
                    r_phase      <= PH_SKIP;
                    r_width_left <= r_max_width;
                    r_accum      <= 64'd0;
                    r_negative   <= 1'b0;
                    r_radix      <= RADIX_10;
                    r_got_digit  <= 1'b0;
                    r_taken      <= 16'd0;
                    r_out_value  <= fin_value;
                    r_out_status <= fin_status;
                    r_out_unused <= fin_unused;
                    r_out_taken  <= r_taken;
                end else begin
                    r_phase      <= n_phase;
                    r_width_left <= n_width_left;
                    r_accum      <= n_accum;
                    r_negative   <= n_negative;
                    r_radix      <= n_radix;
                    r_got_digit  <= n_got_digit;
                    r_taken      <= n_taken;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_taken, r_out_value};
    assign m_axis_tuser  = {r_out_unused, r_out_status};

    // A finished field restarts clean with a result waiting
    `IFP_ASSERT_NEXT(a_fin_clears, i_clk, i_rst_n, in_fire && fin, r_phase == PH_SKIP && r_taken == 16'd0 && !r_got_digit && r_out_valid, "field state not cleared after result")
    // Only a converted result carries a nonzero value
    `IFP_ASSERT(a_err_zero_value, i_clk, i_rst_n, !r_out_valid || r_out_status == STATUS_OK || r_out_value == 64'd0, "error result with nonzero value")
    // After a leading zero the field is octal and already holds a digit
    `IFP_ASSERT(a_zero_octal, i_clk, i_rst_n, r_phase != PH_ZERO || (r_got_digit && r_radix == RADIX_8), "leading-zero state without octal digit")

endmodule
